[hw/rtl/pcmf_pkg.sv]
// Package: constants and request types for the per-channel median filter.
package pcmf_pkg;

    localparam int SAMPLES   = 64;
    localparam int CHANNELS  = 16;
    localparam int IDX_W     = $clog2(SAMPLES);
    localparam int CNT_W     = $clog2(SAMPLES + 1);
    localparam int CH_W      = 4;
    localparam int SMP_W     = 12;
    localparam int RAW_W     = 21;

    typedef struct packed {
        logic [RAW_W-1:0] raw_word;
        logic             last_sample;
    } pcmf_in_t;

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [SMP_W-1:0] median;
        logic             last_of_run;
    } pcmf_out_t;

    // one slot in the cell row
    typedef struct packed {
        logic             valid;
        logic [SMP_W-1:0] sample;
    } pcmf_slot_t;

endpackage

[hw/rtl/pcmf_cell.sv]
// Insertion-sort cell: holds one sample, keeps the row ascending.
module pcmf_cell import pcmf_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             clear,
    input  logic             ins_valid,
    input  logic [SMP_W-1:0] ins_sample,
    input  pcmf_slot_t       left,
    input  logic             left_greater,
    output logic             greater,
    output pcmf_slot_t       slot
);

    pcmf_slot_t slot_reg;
    pcmf_slot_t slot_next;

    // stored value strictly greater than new one (or empty) => shifts right
    assign greater = !slot_reg.valid || (slot_reg.sample > ins_sample);
    assign slot    = slot_reg;

    always_comb begin
        slot_next = slot_reg;
        if (clear) begin
            slot_next.valid = 1'b0;
        end else if (ins_valid && greater) begin
            if (left_greater) begin
                slot_next = left;
            end else begin
                slot_next.valid  = 1'b1;
                slot_next.sample = ins_sample;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg.valid <= 1'b0;
        end else begin
            slot_reg.valid <= slot_next.valid;
        end
        slot_reg.sample <= slot_next.sample;
    end

endmodule

[hw/rtl/pcmf_sort_row.sv]
// Row of sort cells; reads out the cell at sel_idx (the top passes count/2 for the upper median).
module pcmf_sort_row import pcmf_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             clear,
    input  logic             ins_valid,
    input  logic [SMP_W-1:0] ins_sample,
    input  logic [IDX_W-1:0] sel_idx,
    output logic [SMP_W-1:0] sel_sample
);

    pcmf_slot_t slots [SAMPLES];
    logic       gt    [SAMPLES];

    genvar g;
    generate
        for (g = 0; g < SAMPLES; g++) begin : g_cell
            pcmf_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .clear       (clear),
                .ins_valid   (ins_valid),
                .ins_sample  (ins_sample),
                .left        ((g == 0) ? '0 : slots[(g == 0) ? 0 : g-1]),
                .left_greater((g == 0) ? 1'b0 : gt[(g == 0) ? 0 : g-1]),
                .greater     (gt[g]),
                .slot        (slots[g])
            );
        end
    endgenerate

    assign sel_sample = slots[sel_idx].sample;

endmodule

[hw/rtl/per_channel_median_filter_core.sv]
// Top level: sample store, per-channel scan sequencer and result register.
// Words are stored at one per cycle while loading. On the last word the
// block scans channels in ascending order; for each present channel it
// streams the N stored words through a 64-cell insertion-sort row, one
// word per cycle, then reads the cell at count/2. Each present channel
// passes the find, clear, scan and emit states; each absent channel below
// the highest present one passes find only, and an empty block goes from
// find back to load. Input is held off meanwhile. Results sit in an output
// register, so the scan waits only when a result is not taken.
module per_channel_median_filter_core import pcmf_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  pcmf_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output pcmf_out_t m_data
);

    typedef enum logic [2:0] {
        ST_LOAD, ST_FIND, ST_CLEAR, ST_SCAN, ST_EMIT
    } state_t;

    state_t state_reg;

    logic [CH_W+SMP_W-1:0] mem [SAMPLES];
    logic [CH_W+SMP_W-1:0] rd_reg;
    logic [CNT_W-1:0]      fill_reg;
    logic [CHANNELS-1:0]   present_reg;
    logic [CH_W-1:0]       ch_reg;
    logic [CNT_W-1:0]      rd_idx_reg;
    logic                  rd_vld_reg;
    logic [CNT_W-1:0]      n_reg;
    logic                  m_valid_reg;
    pcmf_out_t             m_data_reg;

    logic [4:0]           in_ch;
    logic                 acc;
    logic                 store;
    logic                 ins_valid;
    logic                 clear;
    logic [SMP_W-1:0]     sel_sample;
    logic [IDX_W-1:0]     sel_idx;
    logic [CHANNELS-1:0]  rem_mask;
    logic [CHANNELS-1:0]  later;

    assign in_ch   = s_data.raw_word[20:16];
    assign s_ready = (state_reg == ST_LOAD);
    assign acc     = s_valid && s_ready;
    assign store   = acc && (in_ch < 5'(CHANNELS))
                     && (fill_reg < CNT_W'(SAMPLES));
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign clear     = (state_reg == ST_CLEAR);
    assign ins_valid = (state_reg == ST_SCAN) && rd_vld_reg
                       && (rd_reg[CH_W+SMP_W-1 -: CH_W] == ch_reg);
    assign sel_idx   = n_reg[IDX_W:1];

    // channels above the current one still present
    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            later[i] = (CH_W'(i) > ch_reg);
        end
        rem_mask = present_reg & later;
    end

    pcmf_sort_row u_row (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (clear),
        .ins_valid (ins_valid),
        .ins_sample(rd_reg[SMP_W-1:0]),
        .sel_idx   (sel_idx),
        .sel_sample(sel_sample)
    );

    always_ff @(posedge aclk) begin
        if (store) begin
            mem[fill_reg[IDX_W-1:0]] <= {in_ch[CH_W-1:0], s_data.raw_word[SMP_W-1:0]};
        end
        rd_reg <= mem[rd_idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            fill_reg    <= '0;
            present_reg <= '0;
            ch_reg      <= '0;
            rd_idx_reg  <= '0;
            rd_vld_reg  <= 1'b0;
            n_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_EMIT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_LOAD: begin
                    if (store) begin
                        fill_reg    <= fill_reg + 1'b1;
                        present_reg <= present_reg | (CHANNELS'(1) << in_ch[CH_W-1:0]);
                    end
                    if (acc && s_data.last_sample) begin
                        ch_reg    <= '0;
                        state_reg <= ST_FIND;
                    end
                end
                ST_FIND: begin
                    if (present_reg[ch_reg]) begin
                        state_reg <= ST_CLEAR;
                    end else if (rem_mask == '0) begin
                        fill_reg    <= '0;
                        present_reg <= '0;
                        state_reg   <= ST_LOAD;
                    end else begin
                        ch_reg <= ch_reg + 1'b1;
                    end
                end
                ST_CLEAR: begin
                    rd_idx_reg <= '0;
                    rd_vld_reg <= 1'b0;
                    n_reg      <= '0;
                    state_reg  <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (ins_valid) begin
                        n_reg <= n_reg + 1'b1;
                    end
                    if (rd_idx_reg < fill_reg) begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                        rd_vld_reg <= 1'b1;
                    end else begin
                        rd_vld_reg <= 1'b0;
                        if (!rd_vld_reg) begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg            <= 1'b1;
                        m_data_reg.channel     <= ch_reg;
                        m_data_reg.median      <= sel_sample;
                        m_data_reg.last_of_run <= (rem_mask == '0);
                        if (rem_mask == '0) begin
                            fill_reg    <= '0;
                            present_reg <= '0;
                            state_reg   <= ST_LOAD;
                        end else begin
                            ch_reg    <= ch_reg + 1'b1;
                            state_reg <= ST_FIND;
                        end
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_LOAD) |-> !s_ready) else $error("input taken while busy");
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(SAMPLES)) else $error("fill count overrun");
    a_emit_present: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> present_reg[ch_reg]) else $error("emit absent channel");

endmodule

[sim/per_channel_median_filter_core_tb.sv]
// Testbench for the per-channel median filter: block stimulus, software median, result check.
`timescale 1ns / 100ps

module per_channel_median_filter_core_tb;
    import pcmf_pkg::*;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    pcmf_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    pcmf_out_t m_data;

    per_channel_median_filter_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // predictor state
    logic [SMP_W-1:0] blk_samples[$];
    logic [CH_W-1:0]  blk_chans[$];
    pcmf_out_t        medians_due[$];

    int  mismatches = 0;
    int  results_seen = 0;
    int  words_sent = 0;
    int  blocks_sent = 0;
    bit  no_idle = 1'b0;

    function automatic logic [SMP_W-1:0] upper_median(input logic [CH_W-1:0] ch);
        logic [SMP_W-1:0] v[$];
        logic [SMP_W-1:0] t;
        v = {};
        foreach (blk_chans[i]) if (blk_chans[i] == ch) v.push_back(blk_samples[i]);
        for (int i = 1; i < v.size(); i++) begin
            for (int k = i; k > 0 && v[k-1] > v[k]; k--) begin
                t = v[k]; v[k] = v[k-1]; v[k-1] = t;
            end
        end
        return v[v.size()/2];
    endfunction

    function automatic void predict_word(input pcmf_in_t w);
        logic [4:0] ch;
        bit [CHANNELS-1:0] seen;
        pcmf_out_t r;
        int lastq;
        ch = w.raw_word[20:16];
        if (ch < CHANNELS && blk_samples.size() < SAMPLES) begin
            blk_samples.push_back(w.raw_word[11:0]);
            blk_chans.push_back(ch[CH_W-1:0]);
        end
        if (!w.last_sample) return;
        seen = '0;
        foreach (blk_chans[i]) seen[blk_chans[i]] = 1'b1;
        lastq = -1;
        for (int c = 0; c < CHANNELS; c++) begin
            if (seen[c]) begin
                r.channel = c[CH_W-1:0];
                r.median = upper_median(c[CH_W-1:0]);
                r.last_of_run = 1'b0;
                medians_due.push_back(r);
                lastq = medians_due.size() - 1;
            end
        end
        if (lastq >= 0) medians_due[lastq].last_of_run = 1'b1;
        blk_samples = {};
        blk_chans = {};
        blocks_sent++;
    endfunction

    task automatic send_word(input logic [4:0] ch, input logic [15:0] lo, input bit last);
        pcmf_in_t w;
        int idle_n;
        w.raw_word = {ch, lo};
        w.last_sample = last;
        idle_n = 0;
        while (!no_idle && $urandom_range(99) < 33) idle_n++;
        if (idle_n > 0) begin
            s_valid <= 1'b0;
            repeat (idle_n) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        // ready only changes at the rising edge, so the falling edge shows its value
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        predict_word(w);
        words_sent++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 33);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (medians_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", m_data);
            end else begin
                if (m_data !== medians_due[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp ch %0d med %0d last %0b, got ch %0d med %0d last %0b",
                            medians_due[0].channel, medians_due[0].median,
                            medians_due[0].last_of_run, m_data.channel, m_data.median,
                            m_data.last_of_run);
                end
                void'(medians_due.pop_front());
            end
        end
    end

    task automatic test_extremes;
        send_word(5'd0, 16'h0000, 1'b0);
        send_word(5'd0, 16'hFFFF, 1'b0);
        send_word(5'd15, 16'hF000, 1'b0);
        send_word(5'd15, 16'h0FFF, 1'b0);
        send_word(5'd0, 16'h0800, 1'b1);
        // empty block, then out-of-range only
        send_word(5'd31, 16'hFFFF, 1'b1);
        send_word(5'd16, 16'h0123, 1'b0);
        send_word(5'd31, 16'h0ABC, 1'b1);
        // out-of-range last still closes the block
        send_word(5'd7, 16'h0555, 1'b0);
        send_word(5'd20, 16'h0AAA, 1'b1);
    endtask

    task automatic test_all_channels;
        for (int c = 0; c < CHANNELS; c++)
            send_word(c[4:0], {4'hA, 12'($urandom)}, c == CHANNELS - 1);
    endtask

    task automatic test_store_full;
        for (int i = 0; i < SAMPLES + 4; i++)
            send_word(5'($urandom_range(3)), 16'($urandom), i == SAMPLES + 3);
    endtask

    task automatic test_random_blocks;
        int n;
        logic [4:0] ch;
        for (int b = 0; b < 14; b++) begin
            no_idle = (b >= 5 && b < 8);
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(9) == 0) ch = 5'($urandom_range(16, 31));
                else ch = 5'($urandom_range(0, CHANNELS - 1));
                send_word(ch, 16'($urandom), i == n - 1);
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_all_channels();
        test_store_full();
        test_random_blocks();
        s_valid <= 1'b0;
        while (medians_due.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("sent %0d words in %0d blocks, checked %0d channel medians",
            words_sent, blocks_sent, results_seen);
        if (mismatches == 0 && medians_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end

endmodule
